// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file wmt_checker.sv.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define WMT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("window threshold check failed");

// Clocked property that is also checked during reset.
`define WMT_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("window threshold reset check failed");

`endif

// ===== rtl/core/wmt_pkg.sv =====
// Types, constants and helper functions for the window threshold block.
// Used by the channel interfaces, the top level and the checker; depends on nothing.
`default_nettype none

package wmt_pkg;

  localparam int PIX_BITS      = 8;
  localparam int SUM_BITS      = PIX_BITS + 1;
  localparam int RND_BITS      = SUM_BITS + 1;
  localparam int TYPE_BITS     = 3;
  localparam int SHIFT_BITS    = 4;
  localparam int HALF_BITS     = 8;
  localparam int FIXED_BITS    = 9;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 9;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_TYPE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_V_SHIFT      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_V_HALF       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_H_SHIFT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_H_HALF       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_QUARTER = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_HALF   = 3'd6;

  // Threshold type codes
  localparam logic [TYPE_BITS-1:0] TT_COMP4   = 3'd0;
  localparam logic [TYPE_BITS-1:0] TT_COMP8   = 3'd1;
  localparam logic [TYPE_BITS-1:0] TT_SPREAD4 = 3'd2;
  localparam logic [TYPE_BITS-1:0] TT_SPREAD8 = 3'd3;
  localparam logic [TYPE_BITS-1:0] TT_RANGE4  = 3'd4;

  localparam logic [TYPE_BITS-1:0]  THRESH_TYPE_RST = TT_COMP8;
  localparam logic [FIXED_BITS-1:0] FIXED_RST       = {FIXED_BITS{1'b1}};

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  // Group extremes and centre after the first stage
  typedef struct packed {
    pix_t c;
    pix_t vlo;
    pix_t vhi;
    pix_t hlo;
    pix_t hhi;
  } ext_t;

  // Candidate bases after the second stage
  typedef struct packed {
    pix_t sv;
    pix_t sh;
    pix_t sall;
    pix_t rng;
  } cand_t;

  function automatic pix_t umin(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t umax(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t adif(input pix_t a, input pix_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Largest distance from the centre to either group extreme
  function automatic pix_t spread(input pix_t c, input pix_t lo, input pix_t hi);
    return umax(adif(c, lo), adif(c, hi));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wmt_if.sv =====
// Valid/ready channel interfaces for window input and threshold output.
// Payload types come from wmt_pkg.
`default_nettype none

interface wmt_in_if;
  import wmt_pkg::*;

  logic valid;
  logic ready;
  pix_t pix_top_left;
  pix_t pix_top;
  pix_t pix_top_right;
  pix_t pix_left;
  pix_t pix_center;
  pix_t pix_right;
  pix_t pix_bottom_left;
  pix_t pix_bottom;
  pix_t pix_bottom_right;

  modport source (
    output valid, pix_top_left, pix_top, pix_top_right, pix_left, pix_center,
           pix_right, pix_bottom_left, pix_bottom, pix_bottom_right,
    input  ready
  );

  modport sink (
    input  valid, pix_top_left, pix_top, pix_top_right, pix_left, pix_center,
           pix_right, pix_bottom_left, pix_bottom, pix_bottom_right,
    output ready
  );
endinterface

interface wmt_out_if;
  import wmt_pkg::*;

  logic valid;
  logic ready;
  pix_t quarter_thresh;
  pix_t half_thresh;

  modport source (output valid, quarter_thresh, half_thresh, input ready);
  modport sink   (input valid, quarter_thresh, half_thresh, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/window_motion_threshold_top.sv =====
// Window threshold block: four-stage pipeline from a 3x3 window to two thresholds.
// Depends on wmt_pkg and the channel interfaces in wmt_if.sv.
`default_nettype none

// Takes one 3x3 window per cycle and returns a quarter threshold (t+2)>>2 and a
// half threshold (t+1)>>1, where the base t follows thresh_type. Each window
// passes through the stages in order (group min/max, spreads and range, rounding
// shift and type select, final rounding and fixed override in the output
// register) and a new one enters every cycle. A stall on the output holds the
// occupied stages in place while empty ones keep filling, so the input stays
// ready while a result waits until all four stages hold a window. Configuration
// is written through cfg_we/cfg_index/cfg_wdata and should only change while no
// window is in flight.
module window_motion_threshold_top (
  input  logic                              clk,
  input  logic                              rst_n,
  wmt_in_if.sink                            in_ch,
  wmt_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [wmt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [wmt_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import wmt_pkg::*;

  // Configuration registers
  logic [TYPE_BITS-1:0]  thresh_type_r;
  logic [SHIFT_BITS-1:0] v_shift_r;
  logic [HALF_BITS-1:0]  v_half_r;
  logic [SHIFT_BITS-1:0] h_shift_r;
  logic [HALF_BITS-1:0]  h_half_r;
  logic [FIXED_BITS-1:0] fixed_quarter_r;
  logic [FIXED_BITS-1:0] fixed_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_type_r   <= THRESH_TYPE_RST;
      v_shift_r       <= '0;
      v_half_r        <= '0;
      h_shift_r       <= '0;
      h_half_r        <= '0;
      fixed_quarter_r <= FIXED_RST;
      fixed_half_r    <= FIXED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESH_TYPE:   thresh_type_r   <= cfg_wdata[TYPE_BITS-1:0];
        REG_V_SHIFT:       v_shift_r       <= cfg_wdata[SHIFT_BITS-1:0];
        REG_V_HALF:        v_half_r        <= cfg_wdata[HALF_BITS-1:0];
        REG_H_SHIFT:       h_shift_r       <= cfg_wdata[SHIFT_BITS-1:0];
        REG_H_HALF:        h_half_r        <= cfg_wdata[HALF_BITS-1:0];
        REG_FIXED_QUARTER: fixed_quarter_r <= cfg_wdata[FIXED_BITS-1:0];
        REG_FIXED_HALF:    fixed_half_r    <= cfg_wdata[FIXED_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or the next one moves
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy     = !out_v_r || out_ch.ready;
  assign s3_rdy      = !s3_v_r  || out_rdy;
  assign s2_rdy      = !s2_v_r  || s3_rdy;
  assign s1_rdy      = !s1_v_r  || s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r  <= in_ch.valid;
      if (s2_rdy)  s2_v_r  <= s1_v_r;
      if (s3_rdy)  s3_v_r  <= s2_v_r;
      if (out_rdy) out_v_r <= s3_v_r;
    end
  end

  // Stage 1: group minimum and maximum
  logic use8;
  pix_t v4lo, v4hi, v8lo, v8hi;
  ext_t s1_nxt, s1_r;

  assign use8 = !(thresh_type_r == TT_COMP4 || thresh_type_r == TT_SPREAD4 ||
                  thresh_type_r == TT_RANGE4);

  always_comb begin
    v4lo = umin(in_ch.pix_top, in_ch.pix_bottom);
    v4hi = umax(in_ch.pix_top, in_ch.pix_bottom);
    v8lo = umin(umin(v4lo, in_ch.pix_top_left),
                umin(in_ch.pix_top_right,
                     umin(in_ch.pix_bottom_left, in_ch.pix_bottom_right)));
    v8hi = umax(umax(v4hi, in_ch.pix_top_left),
                umax(in_ch.pix_top_right,
                     umax(in_ch.pix_bottom_left, in_ch.pix_bottom_right)));
    s1_nxt.c   = in_ch.pix_center;
    s1_nxt.vlo = use8 ? v8lo : v4lo;
    s1_nxt.vhi = use8 ? v8hi : v4hi;
    s1_nxt.hlo = umin(in_ch.pix_left, in_ch.pix_right);
    s1_nxt.hhi = umax(in_ch.pix_left, in_ch.pix_right);
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) s1_r <= s1_nxt;
  end

  // Stage 2: spreads from the centre and the full range
  pix_t  alo, ahi;
  cand_t s2_nxt, s2_r;

  always_comb begin
    alo         = umin(s1_r.vlo, s1_r.hlo);
    ahi         = umax(s1_r.vhi, s1_r.hhi);
    s2_nxt.sv   = spread(s1_r.c, s1_r.vlo, s1_r.vhi);
    s2_nxt.sh   = spread(s1_r.c, s1_r.hlo, s1_r.hhi);
    s2_nxt.sall = spread(s1_r.c, alo, ahi);
    s2_nxt.rng  = umax(ahi, s1_r.c) - umin(alo, s1_r.c);
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) s2_r <= s2_nxt;
  end

  // Stage 3: rounding shift per group and base select
  sum_t atv, ath, t_nxt, t_r;

  always_comb begin
    atv = (SUM_BITS'(s2_r.sv) + SUM_BITS'(v_half_r)) >> v_shift_r;
    ath = (SUM_BITS'(s2_r.sh) + SUM_BITS'(h_half_r)) >> h_shift_r;
    case (thresh_type_r)
      TT_COMP4, TT_COMP8:     t_nxt = (atv > ath) ? atv : ath;
      TT_SPREAD4, TT_SPREAD8: t_nxt = SUM_BITS'(s2_r.sall);
      default:                t_nxt = SUM_BITS'(s2_r.rng);
    endcase
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) t_r <= t_nxt;
  end

  // Stage 4: final rounding and fixed override into the output register
  logic [RND_BITS-1:0] q_full, h_full;
  pix_t q_nxt, h_nxt, q_r, h_r;

  always_comb begin
    q_full = (RND_BITS'(t_r) + RND_BITS'(2)) >> 2;
    h_full = (RND_BITS'(t_r) + RND_BITS'(1)) >> 1;
    // sign bit clear means the fixed value replaces the computed one
    q_nxt  = fixed_quarter_r[FIXED_BITS-1] ? PIX_BITS'(q_full)
                                           : PIX_BITS'(fixed_quarter_r[FIXED_BITS-2:0]);
    h_nxt  = fixed_half_r[FIXED_BITS-1] ? PIX_BITS'(h_full)
                                        : PIX_BITS'(fixed_half_r[FIXED_BITS-2:0]);
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s3_v_r) begin
      q_r <= q_nxt;
      h_r <= h_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.quarter_thresh = q_r;
  assign out_ch.half_thresh    = h_r;

endmodule

`default_nettype wire

// ===== rtl/core/wmt_checker.sv =====
// Port-level checks for the window threshold block, bound to its top level.
// Depends on wmt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wmt_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 cfg_we,
  input wmt_pkg::pix_t        out_quarter,
  input wmt_pkg::pix_t        out_half
);
  import wmt_pkg::*;

  logic out_stall;
  assign out_stall = out_valid && !out_ready;

  // Hold a stalled result and its payload
  `WMT_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid)
  `WMT_ASSERT(a_out_stable, clk, rst_n, out_stall |=> ($stable(out_quarter) && $stable(out_half)))
  // A free output side never stops the input
  `WMT_ASSERT(a_flow, clk, rst_n, (out_ready && !cfg_we) |-> in_ready)
  // Drop every result on reset
  `WMT_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind window_motion_threshold_top wmt_checker u_wmt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cfg_we      (cfg_we),
  .out_quarter (out_ch.quarter_thresh),
  .out_half    (out_ch.half_thresh)
);

`default_nettype wire
